/* hw/rtl/osfir_pkg.sv */
// ----------------------------------------------------------------------------
// osfir_pkg
// Shared sizes, derived widths and interface types of the overlap-save
// block FIR filter.
// ----------------------------------------------------------------------------
package osfir_pkg;

  localparam int TAPS      = 512;
  localparam int WINDOW    = 1024;
  localparam int TAP_AW    = $clog2(TAPS);
  localparam int WIN_AW    = $clog2(WINDOW);
  localparam int SMP_W     = 16;
  localparam int TAP_IDX_W = 9;
  localparam int DIGIT_W   = 4;
  localparam int NDIG      = SMP_W / DIGIT_W;
  localparam int SLOT_W    = $clog2(NDIG);
  localparam int PROD_W    = 2 * SMP_W;
  localparam int ACC_W     = PROD_W + TAP_AW;
  localparam int FRAC      = SMP_W - 1;

  typedef struct packed {
    logic load;
    logic last;
  } mac_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [SMP_W-1:0] value;
  } mac_res_t;

endpackage

/* hw/rtl/osfir_ram.sv */
// ----------------------------------------------------------------------------
// osfir_ram
// Generic memory with one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module osfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/osfir_mac.sv */
// ----------------------------------------------------------------------------
// osfir_mac
// Digit-serial multiply-accumulate: the sample operand is consumed four bits
// per cycle against the full tap, products are summed exactly, and each
// finished sum is rounded and saturated to a 16-bit result.
// ----------------------------------------------------------------------------
module osfir_mac import osfir_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [SMP_W-1:0] tap,
  input  logic signed [SMP_W-1:0] smp,
  output mac_res_t                res
);

  localparam int HI_W = SMP_W + 1;
  localparam int S_W  = SMP_W + DIGIT_W + 1;
  localparam int Q_W  = ACC_W + 1 - FRAC;
  localparam int RND  = 1 << (FRAC - 1);

  logic                        active;
  logic [SLOT_W-1:0]           cnt;
  logic                        last_r;
  logic signed [SMP_W-1:0]     tap_r;
  logic [SMP_W-DIGIT_W-1:0]    dig_sr;
  logic signed [HI_W-1:0]      hi;
  logic [SMP_W-1:0]            lo;
  logic                        prod_valid;
  logic                        prod_last;
  logic signed [ACC_W-1:0]     acc;
  logic                        fin;

  logic signed [SMP_W-1:0]     op_tap;
  logic [DIGIT_W-1:0]          dig;
  logic                        top_digit;
  logic signed [DIGIT_W:0]     dig_s;
  logic signed [HI_W-1:0]      hi_in;
  logic signed [S_W-1:0]       pp;
  logic signed [S_W-1:0]       step;
  logic signed [HI_W-1:0]      hi_next;
  logic [SMP_W-1:0]            lo_next;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W:0]       rnd_sum;
  logic signed [Q_W-1:0]       q;
  logic [SMP_W-1:0]            sat;

  // The most significant digit of the sample carries its sign.
  assign op_tap    = ctl.load ? tap : tap_r;
  assign dig       = ctl.load ? smp[DIGIT_W-1:0] : dig_sr[DIGIT_W-1:0];
  assign top_digit = !ctl.load && (cnt == SLOT_W'(NDIG - 1));
  assign dig_s     = signed'({top_digit & dig[DIGIT_W-1], dig});
  assign hi_in     = ctl.load ? '0 : hi;
  assign pp        = S_W'(op_tap) * S_W'(dig_s);
  assign step      = S_W'(hi_in) + pp;
  assign hi_next   = HI_W'(step >>> DIGIT_W);
  assign lo_next   = {step[DIGIT_W-1:0], lo[SMP_W-1:DIGIT_W]};
  assign prod      = signed'({hi[SMP_W-1:0], lo});

  assign rnd_sum = (ACC_W + 1)'(acc) + (ACC_W + 1)'(RND);
  assign q       = rnd_sum[ACC_W:FRAC];

  always_comb begin
    if (q[Q_W-1:SMP_W-1] == '0 || q[Q_W-1:SMP_W-1] == '1) begin
      sat = q[SMP_W-1:0];
    end else if (q[Q_W-1]) begin
      sat = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      cnt        <= '0;
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      acc        <= '0;
      fin        <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      prod_valid <= 1'b0;
      fin        <= 1'b0;
      res.valid  <= 1'b0;
      if (ctl.load) begin
        tap_r  <= tap;
        dig_sr <= smp[SMP_W-1:DIGIT_W];
        hi     <= hi_next;
        lo     <= lo_next;
        last_r <= ctl.last;
        active <= 1'b1;
        cnt    <= SLOT_W'(1);
      end else if (active) begin
        dig_sr <= dig_sr >> DIGIT_W;
        hi     <= hi_next;
        lo     <= lo_next;
        cnt    <= cnt + SLOT_W'(1);
        if (cnt == SLOT_W'(NDIG - 1)) begin
          active     <= 1'b0;
          prod_valid <= 1'b1;
          prod_last  <= last_r;
        end
      end
      if (prod_valid) begin
        acc <= acc + ACC_W'(prod);
        fin <= prod_last;
      end
      if (fin) begin
        res.value <= sat;
        res.valid <= 1'b1;
        acc       <= '0;
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> !active)
    else $error("term loaded while the digit multiplier is still busy");

  a_fin_after_product: assert property (@(posedge clk) disable iff (rst)
    fin |-> $past(prod_valid) && $past(prod_last))
    else $error("sum finished without its last product");

endmodule

/* hw/rtl/overlap_save_block_fir.sv */
// ----------------------------------------------------------------------------
// overlap_save_block_fir
// Mono block FIR filter, overlap-save style, 512 taps over a 1024-sample
// history ring. Each sample request returns the filtered sample of the
// previous block; tap-load requests write one coefficient.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ------------------------------------------
//  request   req_valid / req_stall  kind, sample_in, tap_index, tap_value
//  response  rsp_valid / rsp_stall  sample_out
//
// A tap load is written when accepted; a sample also passes through ST_LOAD
// to fetch its response, as long as the response side drains. The sample
// that completes a block starts the block computation: 512 outputs of 512
// terms via the digit-serial multiplier; no request is taken until it ends.
// Reset starts a clearing pass of the history, tap and result memories;
// requests stall until it ends. A stalled response holds its value.
// ----------------------------------------------------------------------------
module overlap_save_block_fir import osfir_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        kind,
  input  logic signed [SMP_W-1:0]     sample_in,
  input  logic [TAP_IDX_W-1:0]        tap_index,
  input  logic signed [SMP_W-1:0]     tap_value,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic signed [SMP_W-1:0]     sample_out
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_PRIME = 3'd3;
  localparam logic [2:0] ST_RUN   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  localparam logic [TAP_AW-1:0] TAP_LAST = TAP_AW'(TAPS - 1);

  logic [2:0]        state;
  logic [WIN_AW-1:0] clr_addr;
  logic [WIN_AW-1:0] wpos;
  logic [TAP_AW-1:0] fill;
  logic [TAP_AW-1:0] j_f;
  logic [TAP_AW-1:0] k_f;
  logic [SLOT_W-1:0] slot;
  logic [TAP_AW-1:0] wr_j;

  logic              clearing;
  logic              req_accept;
  logic              smp_acc;
  logic              tap_acc;
  logic              tap_ok;

  logic              hist_we;
  logic [WIN_AW-1:0] hist_waddr;
  logic [SMP_W-1:0]  hist_wdata;
  logic [WIN_AW-1:0] hist_raddr;
  logic [SMP_W-1:0]  hist_rdata;

  logic              tap_we;
  logic [TAP_AW-1:0] tap_waddr;
  logic [SMP_W-1:0]  tap_wdata;
  logic [SMP_W-1:0]  tap_rdata;

  logic              res_we;
  logic [TAP_AW-1:0] res_waddr;
  logic [SMP_W-1:0]  res_wdata;
  logic [SMP_W-1:0]  res_rdata;

  mac_ctl_t          mac_ctl;
  mac_res_t          mac_res;

  assign clearing   = (state == ST_CLEAR);
  assign req_stall  = !((state == ST_IDLE) && (!rsp_valid || !rsp_stall));
  assign req_accept = req_valid && !req_stall;
  assign smp_acc    = req_accept && !kind;
  assign tap_acc    = req_accept && kind;
  assign tap_ok     = (32'(tap_index) < TAPS);

  assign hist_we    = clearing || smp_acc;
  assign hist_waddr = clearing ? clr_addr : wpos;
  assign hist_wdata = clearing ? '0 : sample_in;
  assign hist_raddr = wpos - WIN_AW'(TAPS) + WIN_AW'(j_f) - WIN_AW'(k_f);

  assign tap_we    = clearing || (tap_acc && tap_ok);
  assign tap_waddr = clearing ? clr_addr[TAP_AW-1:0] : TAP_AW'(tap_index);
  assign tap_wdata = clearing ? '0 : tap_value;

  assign res_we    = clearing || mac_res.valid;
  assign res_waddr = clearing ? clr_addr[TAP_AW-1:0] : wr_j;
  assign res_wdata = clearing ? '0 : mac_res.value;

  assign mac_ctl.load = (state == ST_RUN) && (slot == '0);
  assign mac_ctl.last = (k_f == TAP_LAST);

  osfir_ram #(.WIDTH(SMP_W), .DEPTH(WINDOW)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  osfir_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_taps (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .raddr (k_f),
    .rdata (tap_rdata)
  );

  osfir_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_result (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (fill),
    .rdata (res_rdata)
  );

  osfir_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .tap (signed'(tap_rdata)),
    .smp (signed'(hist_rdata)),
    .res (mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      wpos      <= WIN_AW'(WINDOW - TAPS);
      fill      <= '0;
      j_f       <= '0;
      k_f       <= '0;
      slot      <= '0;
      wr_j      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (mac_res.valid) begin
        wr_j <= wr_j + TAP_AW'(1);
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + WIN_AW'(1);
          if (clr_addr == WIN_AW'(WINDOW - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (smp_acc) begin
            wpos  <= wpos + WIN_AW'(1);
            fill  <= fill + TAP_AW'(1);
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          sample_out <= signed'(res_rdata);
          rsp_valid  <= 1'b1;
          if (fill == '0) begin
            j_f   <= '0;
            k_f   <= '0;
            state <= ST_PRIME;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PRIME: begin
          slot  <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          slot <= slot + SLOT_W'(1);
          if (mac_ctl.load) begin
            k_f <= k_f + TAP_AW'(1);
            if (k_f == TAP_LAST) begin
              j_f <= j_f + TAP_AW'(1);
              if (j_f == TAP_LAST) begin
                state <= ST_DRAIN;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (mac_res.valid && (wr_j == TAP_LAST)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_rsp_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_LOAD)
    else $error("response raised outside the result fetch");

  a_block_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRIME) |-> (fill == '0) && (wpos[TAP_AW-1:0] == '0))
    else $error("block computation started off a block boundary");

  a_result_in_compute: assert property (@(posedge clk) disable iff (rst)
    mac_res.valid |-> (state == ST_RUN) || (state == ST_DRAIN))
    else $error("filter result produced outside a block computation");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) && $past(state) == ST_RUN |-> (j_f == '0) && (k_f == '0))
    else $error("term counters did not wrap at the end of a block");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the overlap-save block FIR filter against its own cycle-free filter
// model. Tap loads and samples go in through a bursty sender while the
// response side stalls on a pattern of its own. Every response is compared
// with the oldest predicted output. The run covers tap and sample extremes,
// the all-zero first block, tap changes within a block, one full block
// computation and part of the filtered block that follows it.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import osfir_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS = 10;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TAP = 1'b1;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    req_valid = 1'b0;
  logic                    req_stall;
  logic                    kind = KIND_SAMPLE;
  logic signed [SMP_W-1:0] sample_in = '0;
  logic [TAP_IDX_W-1:0]    tap_index = '0;
  logic signed [SMP_W-1:0] tap_value = '0;
  logic                    rsp_valid;
  logic                    rsp_stall = 1'b0;
  logic signed [SMP_W-1:0] sample_out;

  logic signed [SMP_W-1:0] ring_mem [WINDOW];
  logic signed [SMP_W-1:0] coef_mem [TAPS];
  logic signed [SMP_W-1:0] block_out [TAPS];
  int                      ring_wr;
  int                      block_pos;
  int                      blocks_done;
  logic signed [SMP_W-1:0] pending_outputs [$];
  logic signed [SMP_W-1:0] expected_sample;

  int          mismatches = 0;
  int          burst_left = 0;
  int          cycles = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;

  overlap_save_block_fir dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .sample_in  (sample_in),
    .tap_index  (tap_index),
    .tap_value  (tap_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .sample_out (sample_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [SMP_W-1:0] round_to_q15(longint acc);
    longint q;
    q = (acc + 64'sd16384) >>> FRAC;
    if (q > 32767) begin
      q = 32767;
    end else if (q < -32768) begin
      q = -32768;
    end
    return q[SMP_W-1:0];
  endfunction

  task automatic convolve_window();
    longint acc;
    int     wpos;
    for (int j = 0; j < TAPS; j++) begin
      acc = 0;
      for (int k = 0; k < TAPS; k++) begin
        wpos = (WINDOW - TAPS + j + 2 * WINDOW - (k % WINDOW)) % WINDOW;
        acc += longint'(coef_mem[k]) * longint'(ring_mem[(ring_wr + wpos) % WINDOW]);
      end
      block_out[j] = round_to_q15(acc);
    end
  endtask

  task automatic apply_request(logic k, logic signed [SMP_W-1:0] smp,
                               logic [TAP_IDX_W-1:0] idx, logic signed [SMP_W-1:0] val);
    if (k == KIND_TAP) begin
      if (idx < TAPS) begin
        coef_mem[idx] = val;
      end
      return;
    end
    if (block_pos >= TAPS) begin
      block_pos = 0;
    end
    pending_outputs.push_back(block_out[block_pos]);
    ring_mem[ring_wr] = smp;
    ring_wr = (ring_wr + 1) % WINDOW;
    block_pos++;
    if (block_pos >= TAPS) begin
      convolve_window();
      block_pos = 0;
      blocks_done++;
    end
  endtask

  task automatic send_request(logic k, logic signed [SMP_W-1:0] smp,
                              logic [TAP_IDX_W-1:0] idx, logic signed [SMP_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_valid <= 1'b1;
    kind <= k;
    sample_in <= smp;
    tap_index <= idx;
    tap_value <= val;
    do @(posedge clk); while (req_stall);
    apply_request(k, smp, idx, val);
  endtask

  function automatic logic signed [SMP_W-1:0] random_sample();
    case ($urandom_range(0, 15))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return SMP_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly small taps keep the sums out of saturation; a few full-scale
  // ones push them into it.
  function automatic logic signed [SMP_W-1:0] random_tap();
    if ($urandom_range(0, 15) == 0) begin
      return SMP_W'($urandom_range(0, 65535));
    end
    return SMP_W'($urandom_range(0, 1023) - 512);
  endfunction

  task automatic send_random_request(int tap_pct);
    if ($urandom_range(0, 99) < tap_pct) begin
      send_request(KIND_TAP, SMP_W'($urandom_range(0, 65535)),
                   TAP_IDX_W'($urandom_range(0, TAPS - 1)), random_tap());
    end else begin
      send_request(KIND_SAMPLE, random_sample(), TAP_IDX_W'($urandom_range(0, TAPS - 1)),
                   SMP_W'($urandom_range(0, 65535)));
    end
  endtask

  task automatic load_tap_extremes();
    send_request(KIND_TAP, 16'sh7fff, 9'd0, 16'sh8000);
    send_request(KIND_TAP, 16'sh8000, 9'd511, 16'sh7fff);
    send_request(KIND_TAP, 16'sh0000, 9'd1, 16'sh7fff);
    send_request(KIND_TAP, 16'shffff, 9'd510, 16'sh8000);
    send_request(KIND_TAP, 16'sh5555, 9'd2, 16'sh0001);
    send_request(KIND_TAP, 16'shaaaa, 9'd3, 16'shffff);
    send_request(KIND_TAP, 16'sh1234, 9'd256, 16'sh4000);
  endtask

  task automatic send_sample_extremes();
    send_request(KIND_SAMPLE, 16'sh8000, 9'd511, 16'sh7fff);
    send_request(KIND_SAMPLE, 16'sh7fff, 9'd0, 16'sh8000);
    send_request(KIND_SAMPLE, 16'sh0000, 9'd170, 16'sh5555);
    send_request(KIND_SAMPLE, 16'shffff, 9'd341, 16'shaaaa);
    send_request(KIND_SAMPLE, 16'sh0001, 9'd0, 16'sh0000);
    send_request(KIND_SAMPLE, 16'sh5555, 9'd511, 16'shffff);
    send_request(KIND_SAMPLE, 16'shaaaa, 9'd255, 16'sh0001);
    send_request(KIND_SAMPLE, 16'sh8000, 9'd256, 16'sh8000);
  endtask

  // Tap loads land in the middle of the block and take effect at its end.
  task automatic fill_first_block();
    while (blocks_done == 0) begin
      send_random_request(20);
    end
  endtask

  task automatic filter_second_block();
    repeat (100) send_random_request(25);
  endtask

  initial begin
    for (int i = 0; i < WINDOW; i++) begin
      ring_mem[i] = '0;
    end
    for (int i = 0; i < TAPS; i++) begin
      coef_mem[i] = '0;
      block_out[i] = '0;
    end
    ring_wr = WINDOW - TAPS;
    block_pos = 0;
    blocks_done = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_tap_extremes();
    send_sample_extremes();
    fill_first_block();
    filter_second_block();
    req_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("overlap_save_block_fir verification clean");
    end else begin
      $display("overlap_save_block_fir verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_mode <= STALL_NONE;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 2));
        mode_left <= $urandom_range(8, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: rsp_stall <= 1'b0;
        STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
        default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected response: sample_out %0d", sample_out);
        end
      end else begin
        expected_sample = pending_outputs.pop_front();
        if (sample_out !== expected_sample) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("sample_out mismatch: expected %0d, actual %0d",
                     expected_sample, sample_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("overlap_save_block_fir verification failed");
      $finish;
    end
  end

endmodule
